@@ hw/rtl/sp2s_pkg.sv @@
package sp2s_pkg;

    localparam int FRAC_BITS = 12;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // divider widths
    localparam int DIVD_W = 30;
    localparam int DIVS_W = 16;
    localparam int CNT_W  = $clog2(DIVD_W);

    localparam int SPEED_SHIFT = 8;
    localparam logic signed [MUL_W-1:0] SPEED_SCALE = 17'sd100;

    // configuration register indexes
    localparam logic [2:0] REG_P_GAIN      = 3'd0;
    localparam logic [2:0] REG_D_GAIN      = 3'd1;
    localparam logic [2:0] REG_ANGLE_LIMIT = 3'd2;
    localparam logic [2:0] REG_PULSE_RIGHT = 3'd3;
    localparam logic [2:0] REG_PULSE_LEFT  = 3'd4;
    localparam logic [2:0] REG_SPEED_ZERO  = 3'd5;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd6;
    localparam logic [2:0] REG_STOP_ACTIVE = 3'd7;

    // reset values
    localparam logic [15:0] RST_P_GAIN      = 16'd4096;
    localparam logic [15:0] RST_D_GAIN      = 16'd0;
    localparam logic [14:0] RST_ANGLE_LIMIT = 15'd2502;
    localparam logic [11:0] RST_PULSE_RIGHT = 12'd2373;
    localparam logic [11:0] RST_PULSE_LEFT  = 12'd1464;
    localparam logic [15:0] RST_SPEED_ZERO  = 16'd32767;
    localparam logic [14:0] RST_SPEED_LIMIT = 15'd3840;
    localparam logic        RST_STOP_ACTIVE = 1'b1;

    typedef struct packed {
        logic                     start;
        logic signed [DIVD_W-1:0] dividend;
        logic        [DIVS_W-1:0] divisor;
    } div_req_t;

endpackage

@@ hw/rtl/sp2s_mul.sv @@
module sp2s_mul (
    input  logic                                clk,
    input  logic signed [sp2s_pkg::MUL_W-1:0]   op_a,
    input  logic signed [sp2s_pkg::MUL_W-1:0]   op_b,
    output logic signed [sp2s_pkg::PROD_W-1:0]  product
);
    import sp2s_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = product_reg;

endmodule

@@ hw/rtl/sp2s_div.sv @@
module sp2s_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sp2s_pkg::div_req_t                  req,
    output logic                                done,
    output logic signed [sp2s_pkg::DIVD_W-1:0]  quotient
);
    import sp2s_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIVD_W-1:0] mag_reg, mag_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    // restoring divide, one quotient bit per cycle, quotient shifts into mag
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        trial      = {rem_reg, mag_reg[DIVD_W-1]};
        diff       = trial - {1'b0, req.divisor};
        ge         = (trial >= {1'b0, req.divisor});
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            neg_next   = req.dividend[DIVD_W-1];
            mag_next   = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend)
                                                : DIVD_W'(req.dividend);
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            mag_next   = {mag_reg[DIVD_W-2:0], ge};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // floor correction for a negative dividend
    assign quotient = neg_reg ? ($signed(-mag_reg) - DIVD_W'(rem_reg != '0))
                              : $signed(mag_reg);
    assign done = done_reg;

endmodule

@@ hw/rtl/steering_pd_to_servo_pulse.sv @@
// one item at a time: the input stalls from transfer until the result is registered out;
// each item runs the sequencing steps and the 30-step divider; four products share
// one 17x17 multiplier
// a result held by output stall keeps the block in its output state and stalls the input
// reset: async active low, config registers take their defaults,
// previous angle clears to zero, no result pending
module steering_pd_to_servo_pulse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] target_angle,
    input  logic signed [15:0] speed_cmd,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [11:0] pulse_us,
    output logic        [15:0] speed_word,
    output logic signed [15:0] angle_command,
    input  logic               cfg_write,
    input  logic        [2:0]  cfg_index,
    input  logic        [15:0] cfg_data
);
    import sp2s_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL_P     = 4'd1;
    localparam logic [3:0] S_MUL_D     = 4'd2;
    localparam logic [3:0] S_SUM       = 4'd3;
    localparam logic [3:0] S_CLAMP     = 4'd4;
    localparam logic [3:0] S_MUL_PULSE = 4'd5;
    localparam logic [3:0] S_DIV_START = 4'd6;
    localparam logic [3:0] S_SPEED     = 4'd7;
    localparam logic [3:0] S_DIV_WAIT  = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    // configuration
    logic signed [15:0] p_gain_reg, d_gain_reg;
    logic        [14:0] angle_limit_reg, speed_limit_reg;
    logic        [11:0] pulse_right_reg, pulse_left_reg;
    logic        [15:0] speed_zero_reg;
    logic               stop_active_reg;

    logic [3:0]               state_reg, state_next;
    logic signed [15:0]       a_reg, a_next;
    logic signed [15:0]       s_reg, s_next;
    logic signed [15:0]       prev_reg, prev_next;
    logic signed [MUL_W-1:0]  diff_reg, diff_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [15:0]       cmd_reg, cmd_next;
    logic        [15:0]       speed_reg, speed_next;
    logic        [11:0]       pulse_reg, pulse_next;

    logic               out_valid_reg, out_valid_next;
    logic        [11:0] pulse_out_reg, pulse_out_next;
    logic        [15:0] speed_out_reg, speed_out_next;
    logic signed [15:0] cmd_out_reg, cmd_out_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    div_req_t                 div_req;
    logic                     div_done;
    logic signed [DIVD_W-1:0] div_quot;

    logic                     in_xfer;
    logic                     out_free;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] lim_wide;
    logic signed [MUL_W-1:0]  s_sel, s_clamp, slim_wide;
    logic signed [PROD_W-1:0] speed_scaled;

    sp2s_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod)
    );

    sp2s_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        shifted   = acc_reg >>> FRAC_BITS;
        lim_wide  = PROD_W'($signed({1'b0, angle_limit_reg}));
        s_sel     = stop_active_reg ? '0 : MUL_W'(s_reg);
        slim_wide = $signed({2'b00, speed_limit_reg});
        if (s_sel > slim_wide)
            s_clamp = slim_wide;
        else if (s_sel < -slim_wide)
            s_clamp = -slim_wide;
        else
            s_clamp = s_sel;
        // ceiling for positive speeds, floor otherwise
        if (mul_prod > 0)
            speed_scaled = (mul_prod + PROD_W'((1 << SPEED_SHIFT) - 1)) >>> SPEED_SHIFT;
        else
            speed_scaled = mul_prod >>> SPEED_SHIFT;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = MUL_W'(p_gain_reg);
                mul_b = MUL_W'(a_reg);
            end
            S_MUL_D:
            begin
                mul_a = MUL_W'(d_gain_reg);
                mul_b = diff_reg;
            end
            S_MUL_PULSE:
            begin
                mul_a = $signed({5'b0, pulse_right_reg}) - $signed({5'b0, pulse_left_reg});
                if (angle_limit_reg == '0)
                    mul_b = MUL_W'(1);
                else
                    mul_b = $signed({2'b00, angle_limit_reg}) - MUL_W'(cmd_reg);
            end
            S_DIV_START:
            begin
                mul_a = s_clamp;
                mul_b = SPEED_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_DIV_START);
        div_req.dividend = mul_prod[DIVD_W-1:0];
        div_req.divisor  = (angle_limit_reg == '0) ? DIVS_W'(2) : {angle_limit_reg, 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        s_next     = s_reg;
        prev_next  = prev_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        cmd_next   = cmd_reg;
        speed_next = speed_reg;
        pulse_next = pulse_reg;

        out_valid_next = out_valid_reg;
        pulse_out_next = pulse_out_reg;
        speed_out_next = speed_out_reg;
        cmd_out_next   = cmd_out_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    a_next     = target_angle;
                    s_next     = speed_cmd;
                    diff_next  = MUL_W'(target_angle) - MUL_W'(prev_reg);
                    prev_next  = target_angle;
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
                state_next = S_MUL_D;
            S_MUL_D:
            begin
                acc_next   = mul_prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next   = acc_reg + mul_prod;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (shifted > lim_wide)
                    cmd_next = 16'(lim_wide);
                else if (shifted < -lim_wide)
                    cmd_next = 16'(-lim_wide);
                else
                    cmd_next = shifted[15:0];
                state_next = S_MUL_PULSE;
            end
            S_MUL_PULSE:
                state_next = S_DIV_START;
            S_DIV_START:
                state_next = S_SPEED;
            S_SPEED:
            begin
                speed_next = speed_zero_reg + speed_scaled[15:0];
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    pulse_next = pulse_left_reg + div_quot[11:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pulse_out_next = pulse_reg;
                    speed_out_next = speed_reg;
                    cmd_out_next   = cmd_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        s_reg         <= s_next;
        diff_reg      <= diff_next;
        acc_reg       <= acc_next;
        cmd_reg       <= cmd_next;
        speed_reg     <= speed_next;
        pulse_reg     <= pulse_next;
        pulse_out_reg <= pulse_out_next;
        speed_out_reg <= speed_out_next;
        cmd_out_reg   <= cmd_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg      <= RST_P_GAIN;
            d_gain_reg      <= RST_D_GAIN;
            angle_limit_reg <= RST_ANGLE_LIMIT;
            pulse_right_reg <= RST_PULSE_RIGHT;
            pulse_left_reg  <= RST_PULSE_LEFT;
            speed_zero_reg  <= RST_SPEED_ZERO;
            speed_limit_reg <= RST_SPEED_LIMIT;
            stop_active_reg <= RST_STOP_ACTIVE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_P_GAIN:      p_gain_reg      <= cfg_data;
                REG_D_GAIN:      d_gain_reg      <= cfg_data;
                REG_ANGLE_LIMIT: angle_limit_reg <= cfg_data[14:0];
                REG_PULSE_RIGHT: pulse_right_reg <= cfg_data[11:0];
                REG_PULSE_LEFT:  pulse_left_reg  <= cfg_data[11:0];
                REG_SPEED_ZERO:  speed_zero_reg  <= cfg_data;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[14:0];
                REG_STOP_ACTIVE: stop_active_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign pulse_us      = pulse_out_reg;
    assign speed_word    = speed_out_reg;
    assign angle_command = cmd_out_reg;

endmodule

@@ verif/steering_pd_to_servo_pulse_tb.sv @@
module steering_pd_to_servo_pulse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sp2s_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 108;

    typedef struct {
        logic signed [15:0] angle;
        logic signed [15:0] speed;
    } drive_req_t;

    typedef struct {
        logic        [11:0] pulse;
        logic        [15:0] word;
        logic signed [15:0] cmd;
    } servo_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] target_angle = '0;
    logic signed [15:0] speed_cmd = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic        [11:0] pulse_us;
    logic        [15:0] speed_word;
    logic signed [15:0] angle_command;
    logic               cfg_write = 1'b0;
    logic        [2:0]  cfg_index = '0;
    logic        [15:0] cfg_data = '0;

    // register copies kept in step with every write
    logic signed [15:0] p_gain_r      = RST_P_GAIN;
    logic signed [15:0] d_gain_r      = RST_D_GAIN;
    logic        [14:0] angle_limit_r = RST_ANGLE_LIMIT;
    logic        [11:0] pulse_right_r = RST_PULSE_RIGHT;
    logic        [11:0] pulse_left_r  = RST_PULSE_LEFT;
    logic        [15:0] speed_zero_r  = RST_SPEED_ZERO;
    logic        [14:0] speed_limit_r = RST_SPEED_LIMIT;
    logic               stop_r        = RST_STOP_ACTIVE;
    logic signed [15:0] last_angle    = '0;

    drive_req_t drive_req_q[$];
    servo_cmd_t servo_cmd_q[$];
    drive_req_t next_req;
    servo_cmd_t exp_cmd;
    logic       in_xfer = 1'b0;
    int         send_idle_pct = 38;
    int         recv_stall_pct = 69;
    int         n_errors = 0;
    int         cycle_count = 0;

    steering_pd_to_servo_pulse u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .target_angle  (target_angle),
        .speed_cmd     (speed_cmd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pulse_us      (pulse_us),
        .speed_word    (speed_word),
        .angle_command (angle_command),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // floor division, divisor positive
    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic servo_cmd_t predict_servo_cmd(input logic signed [15:0] angle,
                                                     input logic signed [15:0] speed);
        longint a, s, lim, left, right, slim, pd, pulse, scaled;
        servo_cmd_t r;
        a     = angle;
        s     = speed;
        lim   = angle_limit_r;
        left  = pulse_left_r;
        right = pulse_right_r;
        slim  = speed_limit_r;

        // arithmetic shift gives the floor of the q12 product sum
        pd = (longint'(p_gain_r) * a + longint'(d_gain_r) * (a - longint'(last_angle)))
             >>> FRAC_BITS;
        last_angle = angle;
        if (pd > lim)
            pd = lim;
        if (pd < -lim)
            pd = -lim;

        if (lim == 0)
            pulse = left + floor_div(right - left, 2);
        else
            pulse = left + floor_div((right - left) * (lim - pd), 2 * lim);

        if (stop_r)
            s = 0;
        if (s > slim)
            s = slim;
        if (s < -slim)
            s = -slim;
        // round up for forward speed, down otherwise
        if (s > 0)
            scaled = -floor_div(-(s * 100), 256);
        else
            scaled = floor_div(s * 100, 256);

        r.pulse = 12'(pulse);
        r.word  = 16'(longint'(speed_zero_r) + scaled);
        r.cmd   = 16'(pd);
        return r;
    endfunction

    task automatic push_item(input logic signed [15:0] a, input logic signed [15:0] s);
        drive_req_t req;
        req.angle = a;
        req.speed = s;
        drive_req_q.push_back(req);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_P_GAIN:      p_gain_r      = val;
            REG_D_GAIN:      d_gain_r      = val;
            REG_ANGLE_LIMIT: angle_limit_r = val[14:0];
            REG_PULSE_RIGHT: pulse_right_r = val[11:0];
            REG_PULSE_LEFT:  pulse_left_r  = val[11:0];
            REG_SPEED_ZERO:  speed_zero_r  = val;
            REG_SPEED_LIMIT: speed_limit_r = val[14:0];
            REG_STOP_ACTIVE: stop_r        = val[0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] p, input logic [15:0] d,
                             input logic [14:0] lim, input logic [11:0] right,
                             input logic [11:0] left, input logic [15:0] zero,
                             input logic [14:0] slim, input logic stop);
        write_reg(REG_P_GAIN, p);
        write_reg(REG_D_GAIN, d);
        write_reg(REG_ANGLE_LIMIT, 16'(lim));
        write_reg(REG_PULSE_RIGHT, 16'(right));
        write_reg(REG_PULSE_LEFT, 16'(left));
        write_reg(REG_SPEED_ZERO, zero);
        write_reg(REG_SPEED_LIMIT, 16'(slim));
        write_reg(REG_STOP_ACTIVE, 16'(stop));
    endtask

    // sender holds off until every queued item is through and every result is back
    task automatic wait_drained();
        while (drive_req_q.size() != 0 || in_valid || servo_cmd_q.size() != 0)
            @(posedge clk);
    endtask

    // input side: sample transfers, predict on each one
    always @(posedge clk) begin
        in_xfer = in_valid && !in_stall;
        if (in_xfer)
            servo_cmd_q.push_back(predict_servo_cmd(target_angle, speed_cmd));
    end

    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_xfer)) begin
            if (drive_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = drive_req_q.pop_front();
                in_valid     <= 1'b1;
                target_angle <= next_req.angle;
                speed_cmd    <= next_req.speed;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk) begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (servo_cmd_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end
            else begin
                exp_cmd = servo_cmd_q.pop_front();
                if (pulse_us !== exp_cmd.pulse) begin
                    $error("pulse_us expected %0d got %0d", exp_cmd.pulse, pulse_us);
                    n_errors++;
                end
                if (speed_word !== exp_cmd.word) begin
                    $error("speed_word expected %0d got %0d", exp_cmd.word, speed_word);
                    n_errors++;
                end
                if (angle_command !== exp_cmd.cmd) begin
                    $error("angle_command expected %0d got %0d", exp_cmd.cmd, angle_command);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] a;
        logic signed [15:0] s;
        logic        [15:0] p, d, zero;
        logic        [14:0] lim, slim;
        int                 sl;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, speed forced to zero by the stop bit
        push_item(16'sd0, 16'sd0);
        push_item(16'sh7FFF, 16'sh7FFF);
        push_item(16'sh8000, 16'sh8000);
        push_item(16'sd1, -16'sd1);
        push_item(-16'sd1, 16'sd1);
        push_item(16'sd2502, 16'sd100);
        wait_drained();

        // zero angle limit, right below left, speed word wraps upward
        write_all(16'h7FFF, 16'h8000, 15'd0, 12'd0, 12'd4095, 16'hFFFF, 15'h7FFF, 1'b0);
        push_item(16'sh7FFF, 16'sh7FFF);
        push_item(16'sh8000, 16'sh8000);
        push_item(16'sd0, 16'sd1);
        push_item(16'sd100, -16'sd1);
        push_item(-16'sd100, 16'sd0);
        wait_drained();

        // full angle limit, zero speed limit
        write_all(16'h8000, 16'h7FFF, 15'h7FFF, 12'd4095, 12'd0, 16'd0, 15'd0, 1'b0);
        push_item(16'sh7FFF, 16'sd5);
        push_item(16'sh8000, -16'sd5);
        push_item(16'sd0, 16'sd0);
        push_item(16'sd4096, 16'sh7FFF);
        wait_drained();

        // interior mapping, rounding of small speeds, wrap below zero
        write_all(16'd4096, 16'd4096, 15'd4096, 12'd1000, 12'd2000, 16'd0, 15'd256, 1'b0);
        push_item(16'sd1000, -16'sd1);
        push_item(-16'sd2000, -16'sd256);
        push_item(16'sd4096, 16'sd1);
        push_item(-16'sd4096, 16'sd255);
        push_item(16'sd0, 16'sh8000);
        wait_drained();

        a = '0;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                send_idle_pct  = 69;
                recv_stall_pct = 38;
            end
            if (ph == 8) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // moderate gains keep the pd term out of saturation part of the time
            p = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192)) - 16'd4096;
            d = ($urandom_range(3) == 0) ? 16'd0
                : $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192)) - 16'd4096;
            case ($urandom_range(4))
                0:       lim = 15'd0;
                1:       lim = 15'h7FFF;
                2:       lim = 15'($urandom);
                default: lim = 15'($urandom_range(4096, 1));
            endcase
            zero = 16'($urandom);
            slim = $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(4000));
            sl = slim;
            write_all(p, d, lim, 12'($urandom), 12'($urandom), zero, slim,
                      $urandom_range(3) == 0);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(3))
                    0:       a = 16'($urandom);
                    1:       a = 16'($urandom_range(8192)) - 16'd4096;
                    2:       a = a + 16'($urandom_range(64)) - 16'd32;
                    default: a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                endcase
                case ($urandom_range(2))
                    0:       s = 16'($urandom);
                    1:       s = 16'($urandom_range(2 * sl + 200)) - 16'(sl + 100);
                    default: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                endcase
                push_item(a, s);
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ steering_pd_to_servo_pulse.f @@
hw/rtl/sp2s_pkg.sv
hw/rtl/sp2s_mul.sv
hw/rtl/sp2s_div.sv
hw/rtl/steering_pd_to_servo_pulse.sv
verif/steering_pd_to_servo_pulse_tb.sv
